### hdl/sabb_pkg.sv
// Shared types, widths and helper functions for the swept box slab-hit block.
// No dependencies; used by the channel interfaces, the top level and the checker.
package sabb_pkg;

   // field widths
   localparam int CoordW = 20;              // signed Q16.4 edges
   localparam int SizeW  = 19;              // unsigned Q15.4 sizes
   localparam int VelW   = 16;              // signed Q8.8 velocity
   localparam int StepW  = 16;              // unsigned Q4.12 step and time
   localparam int TimeW  = 16;              // signed Q4.12 output time
   localparam int SideW  = 3;

   // internal widths
   localparam int DistW  = 22;              // signed slab distance
   localparam int DmagW  = 21;              // distance magnitude
   localparam int FracSh = 28;              // dist * 2^28 / dir gives Q4.12
   localparam int NumW   = DmagW + FracSh;  // dividend width, one stage per bit
   localparam int DirW   = 32;              // signed v * step
   localparam int DvsW   = 31;              // divisor magnitude
   localparam int QW     = 52;              // signed time, room for infinities

   localparam logic signed [QW-1:0] TNegInf = {1'b1, {(QW-1){1'b0}}};
   localparam logic signed [QW-1:0] TPosInf = {1'b0, {(QW-1){1'b1}}};
   localparam logic signed [QW-1:0] TSatMax = QW'(32767);
   localparam logic signed [QW-1:0] TSatMin = -QW'(32768);

   typedef enum logic [SideW-1:0] {
      SIDE_NONE   = 3'd0,
      SIDE_TOP    = 3'd1,
      SIDE_BOTTOM = 3'd2,
      SIDE_LEFT   = 3'd3,
      SIDE_RIGHT  = 3'd4
   } sabb_side_type;

   // per-item control flags that ride along with the divider
   typedef struct packed {
      logic miss;      // zero ray, or an axis with zero direction outside its slab
      logic x_zero;
      logic y_zero;
      logic dx_neg;
      logic dy_neg;
   } sabb_flag_type;

   // one restoring divider lane: partial remainder, dividend/quotient shift word
   typedef struct packed {
      logic [DvsW-1:0] rem;
      logic [NumW-1:0] nq;
      logic            neg;   // operand signs differ
   } sabb_div_type;

   typedef struct packed {
      sabb_div_type    xi;
      sabb_div_type    xo;
      sabb_div_type    yi;
      sabb_div_type    yo;
      logic [DvsW-1:0] dvs_x;
      logic [DvsW-1:0] dvs_y;
      sabb_flag_type   flg;
   } sabb_stage_type;

   // one quotient bit of restoring division
   function automatic sabb_div_type sabb_div_step(sabb_div_type cur, logic [DvsW-1:0] dvs);
      sabb_div_type   nxt;
      logic [DvsW:0]  trial;
      logic [DvsW:0]  diff;
      logic           qbit;
      nxt   = cur;
      trial = {cur.rem, cur.nq[NumW-1]};
      diff  = trial - {1'b0, dvs};
      qbit  = (trial >= {1'b0, dvs});
      nxt.rem = qbit ? diff[DvsW-1:0] : trial[DvsW-1:0];
      nxt.nq  = {cur.nq[NumW-2:0], qbit};
      return nxt;
   endfunction

   // signed quotient rounded toward minus infinity
   function automatic logic signed [QW-1:0] sabb_floor(sabb_div_type d);
      logic signed [QW-1:0] q;
      q = $signed(QW'(d.nq));
      if (d.neg) begin
         q = -q - $signed(QW'(d.rem != '0));
      end
      return q;
   endfunction

endpackage

### hdl/sabb_req_if.sv
// Request channel: one query beat (two boxes, velocity, step).
// Depends on sabb_pkg for field widths.
interface sabb_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [sabb_pkg::CoordW-1:0]     a_x;
   logic signed [sabb_pkg::CoordW-1:0]     a_y;
   logic        [sabb_pkg::SizeW-1:0]      a_w;
   logic        [sabb_pkg::SizeW-1:0]      a_h;
   logic signed [sabb_pkg::VelW-1:0]       a_vx;
   logic signed [sabb_pkg::VelW-1:0]       a_vy;
   logic signed [sabb_pkg::CoordW-1:0]     b_x;
   logic signed [sabb_pkg::CoordW-1:0]     b_y;
   logic        [sabb_pkg::SizeW-1:0]      b_w;
   logic        [sabb_pkg::SizeW-1:0]      b_h;
   logic        [sabb_pkg::StepW-1:0]      step_time;

   modport source (output valid, a_x, a_y, a_w, a_h, a_vx, a_vy,
                   b_x, b_y, b_w, b_h, step_time, input ready);
   modport sink   (input valid, a_x, a_y, a_w, a_h, a_vx, a_vy,
                   b_x, b_y, b_w, b_h, step_time, output ready);
endinterface

### hdl/sabb_rsp_if.sv
// Response channel: hit side and near time for one query beat.
// Depends on sabb_pkg for field types.
interface sabb_rsp_if;
   logic                                valid;
   logic                                ready;
   sabb_pkg::sabb_side_type             hit_side;
   logic signed [sabb_pkg::TimeW-1:0]   t_near;

   modport source (output valid, hit_side, t_near, input ready);
   modport sink   (input valid, hit_side, t_near, output ready);
endinterface

### hdl/swept_aabb_ray_slab_hit.sv
// Swept box hit test: a box moving by velocity times step against a still box,
// by slab entry/exit times on each axis. Depends on sabb_pkg, sabb_req_if, sabb_rsp_if.
//
// One query beat is taken every cycle while the pipeline advances, and one response
// beat comes out per query, in order. The pipeline is built from four restoring
// dividers (entry and exit time for each axis) that produce one quotient bit per
// pipeline stage over 49 bits, plus an input stage (velocity times step and slab
// distances), a divider load stage, two finishing stages and the output register.
// The whole pipeline advances whenever the output register is empty or being
// taken, so a stall on the response side holds every beat in place.
module swept_aabb_ray_slab_hit (
   input  logic          clock,
   input  logic          reset,
   sabb_req_if.sink      req_bus,
   sabb_rsp_if.source    rsp_bus
);

   localparam int NumW   = sabb_pkg::NumW;
   localparam int DistW  = sabb_pkg::DistW;
   localparam int DirW   = sabb_pkg::DirW;
   localparam int QW     = sabb_pkg::QW;
   localparam int StepWp = sabb_pkg::StepW + 1;

   logic rsp_vld_ff;
   logic adv;
   assign adv = !rsp_vld_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   // ---------------- input stage: direction products and slab distances
   logic                     s0_vld_ff;
   logic signed [DirW-1:0]   dir_x_ff, dir_y_ff, dir_x_in, dir_y_in;
   logic signed [DistW-1:0]  xin_ff, xout_ff, yin_ff, yout_ff;
   logic signed [DistW-1:0]  xin_in, xout_in, yin_in, yout_in;
   logic signed [DirW:0]     prod_x, prod_y;
   logic signed [StepWp-1:0] st_s;

   always_comb begin
      st_s     = $signed({1'b0, req_bus.step_time});
      prod_x   = req_bus.a_vx * st_s;
      prod_y   = req_bus.a_vy * st_s;
      dir_x_in = prod_x[DirW-1:0];
      dir_y_in = prod_y[DirW-1:0];
      xin_in   = DistW'(req_bus.b_x) - DistW'(req_bus.a_x)
               - $signed({{(DistW-sabb_pkg::SizeW){1'b0}}, req_bus.a_w});
      xout_in  = DistW'(req_bus.b_x) - DistW'(req_bus.a_x)
               + $signed({{(DistW-sabb_pkg::SizeW){1'b0}}, req_bus.b_w});
      yin_in   = DistW'(req_bus.b_y) - DistW'(req_bus.a_y)
               - $signed({{(DistW-sabb_pkg::SizeW){1'b0}}, req_bus.a_h});
      yout_in  = DistW'(req_bus.b_y) - DistW'(req_bus.a_y)
               + $signed({{(DistW-sabb_pkg::SizeW){1'b0}}, req_bus.b_h});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= req_bus.valid;
      end
      if (adv) begin
         dir_x_ff <= dir_x_in;
         dir_y_ff <= dir_y_in;
         xin_ff   <= xin_in;
         xout_ff  <= xout_in;
         yin_ff   <= yin_in;
         yout_ff  <= yout_in;
      end
   end

   // ---------------- divider load stage and one quotient bit per stage
   sabb_pkg::sabb_stage_type div_ff [NumW+1];
   sabb_pkg::sabb_stage_type div_in [NumW+1];
   logic [NumW:0]            div_vld_ff;

   function automatic sabb_pkg::sabb_div_type load_lane(logic signed [DistW-1:0] d,
                                                        logic dir_neg);
      sabb_pkg::sabb_div_type  l;
      logic signed [DistW-1:0] m;
      m     = d[DistW-1] ? -d : d;
      l.rem = '0;
      l.nq  = {m[sabb_pkg::DmagW-1:0], {sabb_pkg::FracSh{1'b0}}};
      l.neg = d[DistW-1] ^ dir_neg;
      return l;
   endfunction

   logic signed [DirW-1:0] mag_x, mag_y;
   logic                   x_zero, y_zero, x_ok, y_ok;

   always_comb begin
      mag_x  = dir_x_ff[DirW-1] ? -dir_x_ff : dir_x_ff;
      mag_y  = dir_y_ff[DirW-1] ? -dir_y_ff : dir_y_ff;
      x_zero = (dir_x_ff == '0);
      y_zero = (dir_y_ff == '0);
      x_ok   = !x_zero || (xin_ff <= 0 && xout_ff >= 0);
      y_ok   = !y_zero || (yin_ff <= 0 && yout_ff >= 0);

      div_in[0].xi        = load_lane(xin_ff,  dir_x_ff[DirW-1]);
      div_in[0].xo        = load_lane(xout_ff, dir_x_ff[DirW-1]);
      div_in[0].yi        = load_lane(yin_ff,  dir_y_ff[DirW-1]);
      div_in[0].yo        = load_lane(yout_ff, dir_y_ff[DirW-1]);
      // zero divisor gets 1 so the lane stays defined; its result is unused
      div_in[0].dvs_x     = x_zero ? sabb_pkg::DvsW'(1) : mag_x[sabb_pkg::DvsW-1:0];
      div_in[0].dvs_y     = y_zero ? sabb_pkg::DvsW'(1) : mag_y[sabb_pkg::DvsW-1:0];
      div_in[0].flg.miss  = (x_zero && y_zero) || !x_ok || !y_ok;
      div_in[0].flg.x_zero = x_zero;
      div_in[0].flg.y_zero = y_zero;
      div_in[0].flg.dx_neg = dir_x_ff[DirW-1];
      div_in[0].flg.dy_neg = dir_y_ff[DirW-1];

      for (int k = 1; k <= NumW; k++) begin
         div_in[k]    = div_ff[k-1];
         div_in[k].xi = sabb_pkg::sabb_div_step(div_ff[k-1].xi, div_ff[k-1].dvs_x);
         div_in[k].xo = sabb_pkg::sabb_div_step(div_ff[k-1].xo, div_ff[k-1].dvs_x);
         div_in[k].yi = sabb_pkg::sabb_div_step(div_ff[k-1].yi, div_ff[k-1].dvs_y);
         div_in[k].yo = sabb_pkg::sabb_div_step(div_ff[k-1].yo, div_ff[k-1].dvs_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_vld_ff <= '0;
      end else if (adv) begin
         div_vld_ff <= {div_vld_ff[NumW-1:0], s0_vld_ff};
      end
      if (adv) begin
         for (int k = 0; k <= NumW; k++) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // ---------------- finish 1: floor, order entry/exit, unbounded slabs
   logic                     f1_vld_ff;
   logic signed [QW-1:0]     nx_ff, fx_ff, ny_ff, fy_ff;
   logic signed [QW-1:0]     nx_in, fx_in, ny_in, fy_in;
   logic signed [QW-1:0]     qxi, qxo, qyi, qyo;
   sabb_pkg::sabb_flag_type  f1_flg_ff;

   always_comb begin
      qxi = sabb_pkg::sabb_floor(div_ff[NumW].xi);
      qxo = sabb_pkg::sabb_floor(div_ff[NumW].xo);
      qyi = sabb_pkg::sabb_floor(div_ff[NumW].yi);
      qyo = sabb_pkg::sabb_floor(div_ff[NumW].yo);
      if (div_ff[NumW].flg.x_zero) begin
         nx_in = sabb_pkg::TNegInf;
         fx_in = sabb_pkg::TPosInf;
      end else begin
         nx_in = (qxi > qxo) ? qxo : qxi;
         fx_in = (qxi > qxo) ? qxi : qxo;
      end
      if (div_ff[NumW].flg.y_zero) begin
         ny_in = sabb_pkg::TNegInf;
         fy_in = sabb_pkg::TPosInf;
      end else begin
         ny_in = (qyi > qyo) ? qyo : qyi;
         fy_in = (qyi > qyo) ? qyi : qyo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
      end else if (adv) begin
         f1_vld_ff <= div_vld_ff[NumW];
      end
      if (adv) begin
         nx_ff     <= nx_in;
         fx_ff     <= fx_in;
         ny_ff     <= ny_in;
         fy_ff     <= fy_in;
         f1_flg_ff <= div_ff[NumW].flg;
      end
   end

   // ---------------- finish 2: overlap test, near time, struck side
   logic                     f2_vld_ff;
   logic                     f2_miss_ff, f2_miss_in;
   logic signed [QW-1:0]     tn_ff, tn_in;
   sabb_pkg::sabb_side_type  f2_side_ff, f2_side_in;

   always_comb begin
      // min exit below zero iff either exit is below zero
      f2_miss_in = f1_flg_ff.miss || (nx_ff > fy_ff) || (ny_ff > fx_ff)
                || fx_ff[QW-1] || fy_ff[QW-1];
      if (nx_ff >= ny_ff) begin
         tn_in      = nx_ff;
         f2_side_in = f1_flg_ff.dx_neg ? sabb_pkg::SIDE_RIGHT : sabb_pkg::SIDE_LEFT;
      end else begin
         tn_in      = ny_ff;
         f2_side_in = f1_flg_ff.dy_neg ? sabb_pkg::SIDE_BOTTOM : sabb_pkg::SIDE_TOP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_vld_ff <= 1'b0;
      end else if (adv) begin
         f2_vld_ff <= f1_vld_ff;
      end
      if (adv) begin
         f2_miss_ff <= f2_miss_in;
         tn_ff      <= tn_in;
         f2_side_ff <= f2_side_in;
      end
   end

   // ---------------- output register: saturate
   sabb_pkg::sabb_side_type               rsp_side_ff, rsp_side_in;
   logic signed [sabb_pkg::TimeW-1:0]     rsp_tn_ff, rsp_tn_in;
   logic signed [QW-1:0]                  tn_sat;

   always_comb begin
      if (tn_ff > sabb_pkg::TSatMax) begin
         tn_sat = sabb_pkg::TSatMax;
      end else if (tn_ff < sabb_pkg::TSatMin) begin
         tn_sat = sabb_pkg::TSatMin;
      end else begin
         tn_sat = tn_ff;
      end
      rsp_side_in = f2_miss_ff ? sabb_pkg::SIDE_NONE : f2_side_ff;
      rsp_tn_in   = f2_miss_ff ? '0 : tn_sat[sabb_pkg::TimeW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= f2_vld_ff;
      end
      if (adv) begin
         rsp_side_ff <= rsp_side_in;
         rsp_tn_ff   <= rsp_tn_in;
      end
   end

   assign rsp_bus.valid    = rsp_vld_ff;
   assign rsp_bus.hit_side = rsp_side_ff;
   assign rsp_bus.t_near   = rsp_tn_ff;

endmodule

### hdl/sabb_checker.sv
// Port-level checks for the swept box hit block, bound to its top level.
// Depends on sabb_pkg and swept_aabb_ray_slab_hit.
module sabb_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [sabb_pkg::SideW-1:0]          rsp_hit_side,
   input logic [sabb_pkg::TimeW-1:0]          rsp_t_near
);

   // a response beat held back must stay offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // request side is held exactly while the output is full and stalled
   assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow response stall");

   // a miss carries a zero time
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_side == sabb_pkg::SIDE_NONE |-> rsp_t_near == '0)
      else $error("miss with nonzero time");

   // side code stays within the defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hit_side <= sabb_pkg::SIDE_RIGHT)
      else $error("undefined hit side code");

endmodule

bind swept_aabb_ray_slab_hit sabb_checker u_sabb_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_hit_side (rsp_bus.hit_side),
   .rsp_t_near   (rsp_bus.t_near)
);

### dv/swept_aabb_ray_slab_hit_checker.sv
// Checker for the swept box slab-hit block: watches both channels, predicts each
// response from the query beat and compares in order. Depends on sabb_pkg and the
// request/response interfaces.
`timescale 1ns / 1ps

module swept_aabb_ray_slab_hit_checker (
   input  logic       clock,
   input  logic       reset,
   sabb_req_if        req,
   sabb_rsp_if        rsp,
   output int         fail_count,
   output int         pending
);

   typedef struct {
      sabb_pkg::sabb_side_type             side;
      logic signed [sabb_pkg::TimeW-1:0]   t;
   } hit_type;

   localparam longint NegInf = 64'sh8000_0000_0000_0000;
   localparam longint PosInf = 64'sh7fff_ffff_ffff_ffff;

   hit_type hit_q[$];

   // quotient rounded toward minus infinity
   function automatic longint div_floor(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d != 0) && ((n < 0) != (d < 0))) q--;
      return q;
   endfunction

   // entry/exit times of one slab; ok low when this axis alone misses
   function automatic bit slab_times(longint d_in, longint d_out, longint dir,
                                     output longint t_in, output longint t_out);
      longint p, q;
      t_in  = NegInf;
      t_out = PosInf;
      if (dir == 0) return (d_in <= 0 && d_out >= 0);
      p = div_floor(d_in * 64'sd268435456, dir);
      q = div_floor(d_out * 64'sd268435456, dir);
      t_in  = (p > q) ? q : p;
      t_out = (p > q) ? p : q;
      return 1'b1;
   endfunction

   function automatic hit_type predict_hit(
         logic signed [sabb_pkg::CoordW-1:0] ax, logic signed [sabb_pkg::CoordW-1:0] ay,
         logic [sabb_pkg::SizeW-1:0] aw, logic [sabb_pkg::SizeW-1:0] ah,
         logic signed [sabb_pkg::VelW-1:0] vx, logic signed [sabb_pkg::VelW-1:0] vy,
         logic signed [sabb_pkg::CoordW-1:0] bx, logic signed [sabb_pkg::CoordW-1:0] by,
         logic [sabb_pkg::SizeW-1:0] bw, logic [sabb_pkg::SizeW-1:0] bh,
         logic [sabb_pkg::StepW-1:0] st);
      hit_type r;
      longint  dx, dy, nx, fx, ny, fy, tn, tf;
      r.side = sabb_pkg::SIDE_NONE;
      r.t    = '0;
      dx = longint'(vx) * longint'({1'b0, st});
      dy = longint'(vy) * longint'({1'b0, st});
      if (dx == 0 && dy == 0) return r;
      if (!slab_times(longint'(bx) - ax - longint'({1'b0, aw}),
                      longint'(bx) + longint'({1'b0, bw}) - ax, dx, nx, fx)) return r;
      if (!slab_times(longint'(by) - ay - longint'({1'b0, ah}),
                      longint'(by) + longint'({1'b0, bh}) - ay, dy, ny, fy)) return r;
      if (nx > fy || ny > fx) return r;
      tn = (nx > ny) ? nx : ny;
      tf = (fx < fy) ? fx : fy;
      if (tf < 0) return r;
      if (nx >= ny) r.side = (dx < 0) ? sabb_pkg::SIDE_RIGHT : sabb_pkg::SIDE_LEFT;
      else          r.side = (dy < 0) ? sabb_pkg::SIDE_BOTTOM : sabb_pkg::SIDE_TOP;
      if (tn > 32767)  tn = 32767;
      if (tn < -32768) tn = -32768;
      r.t = tn[sabb_pkg::TimeW-1:0];
      return r;
   endfunction

   initial fail_count = 0;
   assign pending = hit_q.size();

   // queue predictions on query beats, compare on response beats
   always @(posedge clock) begin
      hit_type want;
      if (!reset) begin
         if (req.valid && req.ready)
            hit_q.push_back(predict_hit(req.a_x, req.a_y, req.a_w, req.a_h, req.a_vx,
                                        req.a_vy, req.b_x, req.b_y, req.b_w, req.b_h,
                                        req.step_time));
         if (rsp.valid && rsp.ready) begin
            if (hit_q.size() == 0) begin
               $error("response beat with no query outstanding");
               fail_count++;
            end else begin
               want = hit_q.pop_front();
               if (rsp.hit_side !== want.side) begin
                  $error("hit_side: expected %0d, got %0d", want.side, rsp.hit_side);
                  fail_count++;
               end
               if (rsp.t_near !== want.t) begin
                  $error("t_near: expected %0d, got %0d", want.t, rsp.t_near);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

### dv/swept_aabb_ray_slab_hit_tb.sv
// Testbench top for the swept box slab-hit block: clock, reset, query stimulus and
// response back-pressure; the checker does prediction. Depends on sabb_pkg,
// the channel interfaces, the block and swept_aabb_ray_slab_hit_checker.
`timescale 1ns / 1ps

module swept_aabb_ray_slab_hit_tb;

   localparam int NumRandom = 1800;
   localparam int HoldAt    = 400;    // cycle of the long response hold-off
   localparam int HoldLen   = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic quiet = 1'b0;
   int   fail_count, pending;
   int   n_hits = 0;

   sabb_req_if req_bus ();
   sabb_rsp_if rsp_bus ();

   swept_aabb_ray_slab_hit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   swept_aabb_ray_slab_hit_checker i_chk (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #2 clock = ~clock;

   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int rnd(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // offer one query beat and wait for it to be taken
   task automatic send_query(int ax, int ay, int aw, int ah, int vx, int vy,
                             int bx, int by, int bw, int bh, int st);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = rnd(1, 3);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.a_x       <= sabb_pkg::CoordW'(ax);
      req_bus.a_y       <= sabb_pkg::CoordW'(ay);
      req_bus.a_w       <= sabb_pkg::SizeW'(aw);
      req_bus.a_h       <= sabb_pkg::SizeW'(ah);
      req_bus.a_vx      <= sabb_pkg::VelW'(vx);
      req_bus.a_vy      <= sabb_pkg::VelW'(vy);
      req_bus.b_x       <= sabb_pkg::CoordW'(bx);
      req_bus.b_y       <= sabb_pkg::CoordW'(by);
      req_bus.b_w       <= sabb_pkg::SizeW'(bw);
      req_bus.b_h       <= sabb_pkg::SizeW'(bh);
      req_bus.step_time <= sabb_pkg::StepW'(st);
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain_all();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // count hits for the summary
   always @(posedge clock)
      if (!reset && rsp_bus.valid && rsp_bus.ready
          && rsp_bus.hit_side != sabb_pkg::SIDE_NONE)
         n_hits++;

   // response back-pressure: random short stalls, one long hold-off
   initial begin
      int cyc, n;
      cyc = 0;
      rsp_bus.ready = 1'b1;
      @(negedge reset);
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc == HoldAt) begin
            rsp_bus.ready <= 1'b0;
            repeat (HoldLen) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            n = rnd(1, 3);
            rsp_bus.ready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      int ax, ay, aw, ah, vx, vy, bx, by, bw, bh, st;
      req_bus.valid = 1'b0;
      req_bus.a_x = '0;  req_bus.a_y = '0;  req_bus.a_w = '0;  req_bus.a_h = '0;
      req_bus.a_vx = '0; req_bus.a_vy = '0; req_bus.b_x = '0;  req_bus.b_y = '0;
      req_bus.b_w = '0;  req_bus.b_h = '0;  req_bus.step_time = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero ray, each side, misses, tie, saturation, extremes
      send_query(0, 0, 16, 16, 0, 0, 64, 0, 16, 16, 4096);            // zero velocity
      send_query(0, 0, 16, 16, 256, 256, 64, 0, 16, 16, 0);           // zero step
      send_query(0, 0, 16, 16, 256, 0, 64, 0, 16, 16, 4096);          // left
      send_query(200, 0, 16, 16, -256, 0, 64, 0, 16, 16, 4096);       // right
      send_query(0, 0, 16, 16, 0, 256, 0, 64, 16, 16, 4096);          // top
      send_query(0, 200, 16, 16, 0, -256, 0, 64, 16, 16, 4096);       // bottom
      send_query(0, 0, 16, 16, 256, 0, 64, 100, 16, 16, 4096);        // zero y outside
      send_query(0, 0, 16, 16, 0, 256, 100, 64, 16, 16, 4096);        // zero x outside
      send_query(0, 0, 16, 16, 256, 16, 64, 300, 16, 16, 4096);       // disjoint slabs
      send_query(200, 0, 16, 16, 256, 0, 64, 0, 16, 16, 4096);        // behind
      send_query(0, 0, 16, 16, 256, 256, 64, 64, 16, 16, 4096);       // tie, +x
      send_query(200, 200, 16, 16, -256, -256, 64, 64, 16, 16, 4096); // tie, -x
      send_query(0, 0, 16, 16, 1, 0, 4000, 0, 16, 16, 1);             // saturate high
      send_query(64, 0, 16, 16, 1, 0, 0, 0, 524287, 16, 1);           // saturate low
      send_query(0, 0, 0, 0, 256, 0, 64, 0, 0, 0, 4096);              // zero sizes
      send_query(524287, 524287, 524287, 524287, 32767, 32767,
                 524287, 524287, 524287, 524287, 65535);
      send_query(-524288, -524288, 0, 0, -32768, -32768,
                 -524288, -524288, 0, 0, 65535);
      send_query(-524288, -524288, 524287, 524287, 32767, -32768,
                 524287, 524287, 524287, 524287, 65535);
      send_query(524287, -524288, 524287, 0, -32768, 32767,
                 -524288, 524287, 0, 524287, 1);
      send_query(-524288, 0, 524287, 524287, 32767, 0, 524287, -524288, 524287,
                 524287, 65535);
      drain_all();

      // random: mostly near boxes so slab logic gets exercised, rest full range
      for (int i = 0; i < NumRandom; i++) begin
         if (i == NumRandom / 2) drain_all();
         if (i == NumRandom - 200) quiet <= 1'b1;
         if ($urandom_range(0, 9) < 7) begin
            ax = rnd(-500000, 500000);
            ay = rnd(-500000, 500000);
            aw = rnd(0, 300);  ah = rnd(0, 300);
            bx = ax + rnd(-1500, 1500);
            by = ay + rnd(-1500, 1500);
            bw = rnd(0, 300);  bh = rnd(0, 300);
            case ($urandom_range(0, 4))
               0:       begin vx = 0; vy = rnd(-32768, 32767); end
               1:       begin vx = rnd(-32768, 32767); vy = 0; end
               2:       begin vx = rnd(-600, 600); vy = vx * (($urandom_range(0, 1)) ? 1 : -1); end
               default: begin vx = rnd(-32768, 32767); vy = rnd(-32768, 32767); end
            endcase
            st = ($urandom_range(0, 15) == 0) ? 0 : rnd(0, 65535);
         end else begin
            ax = rnd(-524288, 524287); ay = rnd(-524288, 524287);
            aw = rnd(0, 524287);       ah = rnd(0, 524287);
            vx = rnd(-32768, 32767);   vy = rnd(-32768, 32767);
            bx = rnd(-524288, 524287); by = rnd(-524288, 524287);
            bw = rnd(0, 524287);       bh = rnd(0, 524287);
            st = rnd(0, 65535);
         end
         send_query(ax, ay, aw, ah, vx, vy, bx, by, bw, bh, st);
      end
      req_bus.valid <= 1'b0;

      // drain, then let the pipeline settle
      for (int k = 0; k < 100000 && pending != 0; k++) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Ran %0d queries (directed side, miss, tie and saturation cases plus random),",
               NumRandom + 20);
      $display("%0d responses reported a hit; back-pressure included a long hold-off.", n_hits);
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         if (pending != 0) $error("%0d responses never arrived", pending);
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
